@@ rtl/dmwbc_pkg.sv @@
`default_nettype none

package dmwbc_pkg;

    // Sizes of the cache and its RAM. NUM_LINES and LINE_WORDS are powers of two, at least 2.
    localparam int RAM_WORDS  = 1024;
    localparam int NUM_LINES  = 4;
    localparam int LINE_WORDS = 4;

    localparam int ADDR_W = 11;
    localparam int DATA_W = 32;
    localparam int CNT32_W = 32;

    localparam int RA_W   = $clog2(RAM_WORDS);
    localparam int OFF_W  = $clog2(LINE_WORDS);
    localparam int IDX_W  = $clog2(NUM_LINES);
    localparam int TAG_W  = RA_W - IDX_W - OFF_W;
    localparam int LM_W   = IDX_W + OFF_W;
    localparam int LM_WORDS = NUM_LINES * LINE_WORDS;
    localparam int WCNT_W = OFF_W + 1;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_RAM_WRITE = 2'd2,
        OP_RAM_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RAMRD,
        S_LINERD,
        S_WB,
        S_FILL,
        S_RESP
    } state_t;

    // Request from the controller to the backing RAM.
    typedef struct packed {
        logic              rd_en;
        logic [RA_W-1:0]   rd_addr;
        logic              wr_en;
        logic [RA_W-1:0]   wr_addr;
        logic [DATA_W-1:0] wr_data;
    } ram_req_t;

endpackage

`default_nettype wire

@@ rtl/dmwbc_if.sv @@
`default_nettype none

interface dmwbc_req_if
    import dmwbc_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output opcode, output address, output write_data,
                    input ready);
    modport sink (input valid, input opcode, input address, input write_data,
                  output ready);
endinterface

interface dmwbc_rsp_if
    import dmwbc_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  read_data;
    logic               was_hit;
    logic [CNT32_W-1:0] hit_total;
    logic [CNT32_W-1:0] miss_total;

    modport source (output valid, output read_data, output was_hit, output hit_total,
                    output miss_total, input ready);
    modport sink (input valid, input read_data, input was_hit, input hit_total,
                  input miss_total, output ready);
endinterface

interface dmwbc_cfg_if;
    logic valid;
    logic ready;
    logic cache_enable;

    modport source (output valid, output cache_enable, input ready);
    modport sink (input valid, input cache_enable, output ready);
endinterface

`default_nettype wire

@@ rtl/dmwbc_ram.sv @@
`default_nettype none

module dmwbc_ram
    import dmwbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ram_req_t          req,
    output logic [DATA_W-1:0]      rd_data,
    output logic                   busy
);

    logic [DATA_W-1:0] mem [RAM_WORDS];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clr_active_reg;
    logic              clr_active_next;
    logic [RA_W-1:0]   clr_idx_reg;
    logic [RA_W-1:0]   clr_idx_next;

    // Zeroing sweep after reset, one word per cycle.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            clr_idx_next = clr_idx_reg + RA_W'(1);
            if (clr_idx_reg == RA_W'(RAM_WORDS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

`default_nettype wire

@@ rtl/direct_mapped_writeback_cache.sv @@
`default_nettype none

// Direct-mapped write-back, write-allocate cache with its backing word RAM, both inside.
// One access is handled at a time. A read that hits reads the line memory and a backdoor or
// uncached read reads the RAM before the result; a write that hits, a backdoor or uncached
// write and an out-of-range address go straight to the result. A clean miss fills the line
// and a dirty miss first writes the victim line back; the write-back and the line fill each
// move one word per cycle through the line memory and the single-ported sides of the RAM,
// whose reads are registered. A result waiting on rsp does not keep the next request from
// being taken, but that request's result waits for the slot. After reset the RAM is zeroed
// in a sweep, during which no request is taken; cache_enable writes are taken at any time
// and should only be issued while the block is idle.
module direct_mapped_writeback_cache
    import dmwbc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dmwbc_req_if.sink  req,
    dmwbc_rsp_if.source rsp,
    dmwbc_cfg_if.sink  cfg
);

    state_t state_reg;
    state_t state_next;

    op_t                 op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [DATA_W-1:0]   wdata_reg;
    logic                enable_reg;

    logic [NUM_LINES-1:0] valid_reg;
    logic [NUM_LINES-1:0] valid_next;
    logic [NUM_LINES-1:0] dirty_reg;
    logic [NUM_LINES-1:0] dirty_next;
    logic [TAG_W-1:0]     tag_reg [NUM_LINES];
    logic [TAG_W-1:0]     tag_next [NUM_LINES];

    logic [CNT32_W-1:0] hit_count_reg;
    logic [CNT32_W-1:0] hit_count_next;
    logic [CNT32_W-1:0] miss_count_reg;
    logic [CNT32_W-1:0] miss_count_next;
    logic [WCNT_W-1:0]  cnt_reg;
    logic [WCNT_W-1:0]  cnt_next;
    logic [DATA_W-1:0]  rd_reg;
    logic [DATA_W-1:0]  rd_next;
    logic               hit_reg;
    logic               hit_next;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic [DATA_W-1:0]  out_data_reg;
    logic               out_hit_reg;
    logic [CNT32_W-1:0] out_hits_reg;
    logic [CNT32_W-1:0] out_misses_reg;

    // line data memory
    logic [DATA_W-1:0] line_mem [LM_WORDS];
    logic [DATA_W-1:0] lm_q_reg;
    logic              lm_re;
    logic [LM_W-1:0]   lm_raddr;
    logic              lm_we;
    logic [LM_W-1:0]   lm_waddr;
    logic [DATA_W-1:0] lm_wdata;

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_q;
    logic              ram_busy;

    logic              req_ready;
    logic              req_xfer;
    logic              slot_free;
    logic              in_range;
    logic [IDX_W-1:0]  a_idx;
    logic [OFF_W-1:0]  a_off;
    logic [TAG_W-1:0]  a_tag;
    logic [RA_W-1:0]   a_ram;
    logic              is_ram_wr;
    logic              is_ram_rd;
    logic              lookup_hit;
    logic              victim_dirty;
    logic              last_word;
    logic [OFF_W-1:0]  cur_k;
    logic [OFF_W-1:0]  prev_k;
    logic [RA_W-1:0]   wb_addr;
    logic [RA_W-1:0]   fill_addr;
    logic [RA_W-1:0]   fill_prev_addr;
    logic              wb_ok;
    logic              fill_ok;
    logic [DATA_W-1:0] fill_word;

    dmwbc_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (ram_q),
        .busy    (ram_busy)
    );

    assign req_ready = (state_reg == S_IDLE) && !ram_busy;
    assign req.ready = req_ready;
    assign req_xfer  = req.valid && req_ready;
    assign cfg.ready = 1'b1;
    assign slot_free = !rsp_valid_reg || rsp.ready;

    assign in_range     = ({1'b0, addr_reg} < (ADDR_W + 1)'(RAM_WORDS));
    assign a_off        = addr_reg[OFF_W-1:0];
    assign a_idx        = addr_reg[OFF_W +: IDX_W];
    assign a_tag        = addr_reg[OFF_W + IDX_W +: TAG_W];
    assign a_ram        = addr_reg[RA_W-1:0];
    assign is_ram_wr    = (op_reg == OP_RAM_WRITE) || ((op_reg == OP_WRITE) && !enable_reg);
    assign is_ram_rd    = (op_reg == OP_RAM_READ) || ((op_reg == OP_READ) && !enable_reg);
    assign lookup_hit   = valid_reg[a_idx] && (tag_reg[a_idx] == a_tag);
    assign victim_dirty = valid_reg[a_idx] && dirty_reg[a_idx];

    // Word counter runs 0..LINE_WORDS; memory writes trail the reads, using the word index before the current one.
    assign last_word      = (cnt_reg == WCNT_W'(LINE_WORDS));
    assign cur_k          = cnt_reg[OFF_W-1:0];
    assign prev_k         = OFF_W'(cnt_reg - WCNT_W'(1));
    assign wb_addr        = {tag_reg[a_idx], a_idx, prev_k};
    assign fill_addr      = {a_tag, a_idx, cur_k};
    assign fill_prev_addr = {a_tag, a_idx, prev_k};
    assign wb_ok          = ({1'b0, wb_addr} < (RA_W + 1)'(RAM_WORDS));
    assign fill_ok        = ({1'b0, fill_prev_addr} < (RA_W + 1)'(RAM_WORDS));
    assign fill_word      = fill_ok ? ram_q : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!in_range || is_ram_wr)
                begin
                    state_next = S_RESP;
                end
                else if (is_ram_rd)
                begin
                    state_next = S_RAMRD;
                end
                else if (lookup_hit)
                begin
                    state_next = (op_reg == OP_READ) ? S_LINERD : S_RESP;
                end
                else
                begin
                    state_next = victim_dirty ? S_WB : S_FILL;
                end
            end
            S_RAMRD, S_LINERD:
            begin
                state_next = S_RESP;
            end
            S_WB:
            begin
                if (last_word)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (last_word)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        tag_next        = tag_reg;
        hit_count_next  = hit_count_reg;
        miss_count_next = miss_count_reg;
        cnt_next        = cnt_reg;
        rd_next         = rd_reg;
        hit_next        = hit_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        lm_re           = 1'b0;
        lm_raddr        = {a_idx, a_off};
        lm_we           = 1'b0;
        lm_waddr        = {a_idx, a_off};
        lm_wdata        = wdata_reg;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = a_ram;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = a_ram;
        ram_req.wr_data = wdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_LOOK:
            begin
                rd_next  = '0;
                hit_next = 1'b0;
                cnt_next = '0;
                if (!in_range)
                begin
                end
                else if (is_ram_wr)
                begin
                    ram_req.wr_en = 1'b1;
                end
                else if (is_ram_rd)
                begin
                    ram_req.rd_en = 1'b1;
                end
                else if (lookup_hit)
                begin
                    hit_next       = 1'b1;
                    hit_count_next = hit_count_reg + CNT32_W'(1);
                    if (op_reg == OP_READ)
                    begin
                        lm_re = 1'b1;
                    end
                    else
                    begin
                        lm_we             = 1'b1;
                        dirty_next[a_idx] = 1'b1;
                    end
                end
                else
                begin
                    miss_count_next = miss_count_reg + CNT32_W'(1);
                end
            end
            S_RAMRD:
            begin
                rd_next = ram_q;
            end
            S_LINERD:
            begin
                rd_next = lm_q_reg;
            end
            S_WB:
            begin
                cnt_next = last_word ? '0 : cnt_reg + WCNT_W'(1);
                if (!last_word)
                begin
                    lm_re    = 1'b1;
                    lm_raddr = {a_idx, cur_k};
                end
                if (cnt_reg != '0)
                begin
                    ram_req.wr_en   = wb_ok;
                    ram_req.wr_addr = wb_addr;
                    ram_req.wr_data = lm_q_reg;
                end
            end
            S_FILL:
            begin
                cnt_next = cnt_reg + WCNT_W'(1);
                if (!last_word)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = fill_addr;
                end
                if (cnt_reg != '0)
                begin
                    lm_we    = 1'b1;
                    lm_waddr = {a_idx, prev_k};
                    lm_wdata = fill_word;
                    if (prev_k == a_off)
                    begin
                        if (op_reg == OP_WRITE)
                        begin
                            lm_wdata = wdata_reg;
                        end
                        else
                        begin
                            rd_next = fill_word;
                        end
                    end
                end
                if (last_word)
                begin
                    valid_next[a_idx] = 1'b1;
                    dirty_next[a_idx] = (op_reg == OP_WRITE);
                    tag_next[a_idx]   = a_tag;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            enable_reg     <= 1'b1;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            tag_reg        <= '{default: '0};
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
            cnt_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            dirty_reg      <= dirty_next;
            tag_reg        <= tag_next;
            hit_count_reg  <= hit_count_next;
            miss_count_reg <= miss_count_next;
            cnt_reg        <= cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg.valid)
            begin
                enable_reg <= cfg.cache_enable;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg    <= op_t'(req.opcode);
            addr_reg  <= req.address;
            wdata_reg <= req.write_data;
        end
        rd_reg  <= rd_next;
        hit_reg <= hit_next;
        if ((state_reg == S_RESP) && slot_free)
        begin
            out_data_reg   <= rd_reg;
            out_hit_reg    <= hit_reg;
            out_hits_reg   <= hit_count_reg;
            out_misses_reg <= miss_count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lm_we)
        begin
            line_mem[lm_waddr] <= lm_wdata;
        end
        if (lm_re)
        begin
            lm_q_reg <= line_mem[lm_raddr];
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.was_hit    = out_hit_reg;
    assign rsp.hit_total  = out_hits_reg;
    assign rsp.miss_total = out_misses_reg;

endmodule

`default_nettype wire
